// ===== rtl/core/ptds_pkg.sv =====
package ptds_pkg;

	// sizes
	localparam int unsigned DEF_MAX_TASKS = 32;
	localparam int unsigned TIME_W        = 32;
	localparam int unsigned IDX_W         = 5;
	localparam logic [TIME_W-1:0] ARP_RESET = 32'd10;

	// input word
	typedef struct packed {
		logic              action;
		logic [TIME_W-1:0] now_time;
		logic [TIME_W-1:0] period;
		logic              func_present;
	} ptds_in_t;

	// result word
	typedef struct packed {
		logic             kind;
		logic             accepted;
		logic [IDX_W-1:0] task_index;
		logic             last;
	} ptds_out_t;

	// action codes
	localparam logic ACT_REGISTER = 1'b0;
	localparam logic ACT_TICK     = 1'b1;

	// result kinds
	localparam logic KIND_REG_ANSWER = 1'b0;
	localparam logic KIND_DUE        = 1'b1;

	// one task table entry
	typedef struct packed {
		logic              present;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] last_run;
	} ptds_entry_t;

	// sequencer steps
	typedef enum logic [2:0] {
		ST_WAIT,
		ST_DISP,
		ST_REG,
		ST_SCAN,
		ST_FLUSH
	} ptds_step_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_ACCEPT,
		C_TICK,
		C_OUT_FREE,
		C_SCAN_DONE,
		C_FLUSH_DONE
	} ptds_cond_t;

	// control word
	typedef struct packed {
		logic       take_in;
		logic       do_reg;
		logic       do_scan;
		logic       do_flush;
		ptds_cond_t cond;
		ptds_step_t tgt_true;
		ptds_step_t tgt_false;
	} ptds_ctrl_t;

	// microprogram
	function automatic ptds_ctrl_t ptds_rom(input ptds_step_t step);
		ptds_ctrl_t w;
		w = '{take_in: 1'b0, do_reg: 1'b0, do_scan: 1'b0, do_flush: 1'b0,
			cond: C_ACCEPT, tgt_true: ST_WAIT, tgt_false: ST_WAIT};
		unique case (step)
			ST_WAIT: begin
				w.take_in   = 1'b1;
				w.cond      = C_ACCEPT;
				w.tgt_true  = ST_DISP;
				w.tgt_false = ST_WAIT;
			end
			ST_DISP: begin
				w.cond      = C_TICK;
				w.tgt_true  = ST_SCAN;
				w.tgt_false = ST_REG;
			end
			ST_REG: begin
				w.do_reg    = 1'b1;
				w.cond      = C_OUT_FREE;
				w.tgt_true  = ST_WAIT;
				w.tgt_false = ST_REG;
			end
			ST_SCAN: begin
				w.do_scan   = 1'b1;
				w.cond      = C_SCAN_DONE;
				w.tgt_true  = ST_FLUSH;
				w.tgt_false = ST_SCAN;
			end
			ST_FLUSH: begin
				w.do_flush  = 1'b1;
				w.cond      = C_FLUSH_DONE;
				w.tgt_true  = ST_WAIT;
				w.tgt_false = ST_FLUSH;
			end
			default: begin
				w.cond      = C_ACCEPT;
				w.tgt_true  = ST_WAIT;
				w.tgt_false = ST_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/periodic_task_due_scheduler.sv =====
// periodic task due scheduler
//
// input channel in_valid/in_stall carries one ptds_in_t word. a register
// word appends a task and answers with one result word (accepted, slot, last).
// a tick word scans the registered slots in order and returns one result
// word per due task, the final one marked last; a tick with nothing due
// returns no word at all.
// output channel out_valid/out_stall carries ptds_out_t words from an output
// register, so the block goes on working while a finished word waits.
// cfg_we/cfg_wdata writes the always-run period (10 after reset).
// a register word passes the dispatch and register steps; its answer is
// loaded when the output register is free, and the next word is then taken.
// a tick word reads one table slot per cycle while the scan is not paused.
// one word is worked on at a time; the next is taken once the last result
// of the previous one is in the output register.
// when the receiver stalls, the output word holds and the scan pauses at
// the next due task until the output register frees up.
// reset (arst_n low) empties the table and restores the always-run period;
// table contents are not cleared, only slots below the task count are read.
module periodic_task_due_scheduler
	import ptds_pkg::*;
#(
	parameter int unsigned MAX_TASKS = DEF_MAX_TASKS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ptds_in_t          in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output ptds_out_t         out_word,
	input  logic              cfg_we,
	input  logic [TIME_W-1:0] cfg_wdata
);

	localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int unsigned ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	// sequencer
	ptds_step_t step_q, step_d;
	ptds_ctrl_t ctrl;
	logic       cond_met;

	// registers
	logic [TIME_W-1:0] arp_q;
	ptds_in_t          item_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic              pend_q;
	logic [ADDR_W-1:0] pend_idx_q;
	logic              out_valid_q;
	ptds_out_t         out_q;

	// table read stage
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_idx_s1;
	ptds_entry_t       rd_data_s1;
	ptds_entry_t       mem [MAX_TASKS];

	// datapath
	logic              in_acc;
	logic              out_free;
	logic [TIME_W-1:0] elapsed;
	logic              hit;
	logic              scan_hold;
	logic              scan_adv;
	logic              issue_rd;
	logic              table_full;
	logic              reg_go;
	logic              flush_go;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	ptds_entry_t       mem_wdata;
	logic              out_load;
	ptds_out_t         out_d;
	logic [ADDR_W+IDX_W-1:0] pend_ext;
	logic [ADDR_W+IDX_W-1:0] cnt_ext;

	// control word fetch
	always_comb begin
		ctrl = ptds_rom(step_q);
	end

	// jump condition and next step
	always_comb begin
		unique case (ctrl.cond)
			C_ACCEPT:     cond_met = in_acc;
			C_TICK:       cond_met = (item_q.action == ACT_TICK);
			C_OUT_FREE:   cond_met = out_free;
			C_SCAN_DONE:  cond_met = (idx_q == count_q) && !rd_vld_s1;
			C_FLUSH_DONE: cond_met = !pend_q || out_free;
			default:      cond_met = 1'b0;
		endcase
		step_d = cond_met ? ctrl.tgt_true : ctrl.tgt_false;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	// handshakes
	assign in_stall  = !ctrl.take_in;
	assign in_acc    = in_valid && ctrl.take_in;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// due check on the slot just read
	assign elapsed = item_q.now_time - rd_data_s1.last_run;
	assign hit = rd_vld_s1 && rd_data_s1.present
		&& ((rd_data_s1.period == arp_q) || (elapsed >= rd_data_s1.period));

	// scan flow: pause only when a second due task finds the output busy
	assign scan_hold  = ctrl.do_scan && hit && pend_q && !out_free;
	assign scan_adv   = ctrl.do_scan && !scan_hold;
	assign issue_rd   = scan_adv && (idx_q != count_q);
	assign table_full = (count_q == CNT_W'(MAX_TASKS));
	assign reg_go     = ctrl.do_reg && out_free;
	assign flush_go   = ctrl.do_flush && pend_q && out_free;

	assign pend_ext = {{IDX_W{1'b0}}, pend_idx_q};
	assign cnt_ext  = {{IDX_W{1'b0}}, count_q[ADDR_W-1:0]};

	// table write port and result selection
	always_comb begin
		mem_we    = (reg_go && !table_full) || (scan_adv && hit);
		mem_waddr = reg_go ? count_q[ADDR_W-1:0] : rd_idx_s1;
		if (reg_go) begin
			mem_wdata = '{present: item_q.func_present, period: item_q.period,
				last_run: item_q.now_time};
		end else begin
			mem_wdata = '{present: rd_data_s1.present, period: rd_data_s1.period,
				last_run: item_q.now_time};
		end
		out_load = 1'b0;
		out_d    = '{kind: KIND_DUE, accepted: 1'b0,
			task_index: pend_ext[IDX_W-1:0], last: 1'b0};
		priority if (reg_go) begin
			out_load = 1'b1;
			out_d.kind = KIND_REG_ANSWER;
			out_d.last = 1'b1;
			if (table_full) begin
				out_d.accepted   = 1'b0;
				out_d.task_index = '0;
			end else begin
				out_d.accepted   = 1'b1;
				out_d.task_index = cnt_ext[IDX_W-1:0];
			end
		end else if (scan_adv && hit && pend_q) begin
			out_load = 1'b1;
		end else if (flush_go) begin
			out_load = 1'b1;
			out_d.last = 1'b1;
		end else begin
			out_load = 1'b0;
		end
	end

	// task table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue_rd) begin
			rd_data_s1 <= mem[idx_q[ADDR_W-1:0]];
			rd_idx_s1  <= idx_q[ADDR_W-1:0];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arp_q       <= ARP_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				arp_q <= cfg_wdata;
			end
			if (reg_go && !table_full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (in_acc) begin
				idx_q     <= '0;
				pend_q    <= 1'b0;
				rd_vld_s1 <= 1'b0;
			end else if (scan_adv) begin
				rd_vld_s1 <= issue_rd;
				if (issue_rd) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (hit) begin
					pend_q <= 1'b1;
				end
			end else if (flush_go) begin
				pend_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_word;
		end
		if (scan_adv && hit) begin
			pend_idx_q <= rd_idx_s1;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TASKS))
		else $error("task count beyond table size");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (step_q == ST_DISP))
		else $error("accepted word not dispatched");

	a_reg_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (out_d.kind == KIND_REG_ANSWER)) |-> out_d.last)
		else $error("register answer not marked last");

	a_hold_keeps_slot: assert property (@(posedge clk) disable iff (!arst_n)
		scan_hold |=> (rd_vld_s1 && $stable(rd_idx_s1) && pend_q))
		else $error("scan lost the slot while paused");

endmodule
